### design/olir_pkg.sv
// Shared types and constants for the ordered list insert/remove unit.
`default_nettype none

package olir_pkg;

  localparam int CAPACITY_DEFAULT = 32;
  localparam int VALUE_W          = 32;
  localparam int POS_W            = 5;
  localparam int REQ_W            = 2;
  localparam int QUEUE_DEPTH      = 2;

  // Request type codes as they arrive on req_type.
  localparam logic [REQ_W-1:0] REQ_PUSH_FRONT = 2'd0;
  localparam logic [REQ_W-1:0] REQ_PUSH_BACK  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_REMOVE     = 2'd2;

  typedef enum logic [1:0] {
    OP_NONE,
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_REMOVE
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    op_t                       op;
    logic signed [VALUE_W-1:0] value;
    logic [POS_W-1:0]          position;
    status_t                   status;
  } cmd_t;

endpackage

`default_nettype wire

### design/olir_ram.sv
// Generic single write port, single read port RAM with registered read data.
`default_nettype none

module olir_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

### design/olir_front.sv
// Front end: accepts requests, classifies them against a shadow count and queues commands.
`default_nettype none

module olir_front #(
  parameter int CAPACITY = olir_pkg::CAPACITY_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              start,
  input  wire logic                              q_full,
  input  wire logic [olir_pkg::REQ_W-1:0]        req_type,
  input  wire logic signed [olir_pkg::VALUE_W-1:0] value,
  input  wire logic [olir_pkg::POS_W-1:0]        position,
  output logic                                   busy,
  output logic                                   push,
  output olir_pkg::cmd_t                         cmd
);

  localparam int CW = $clog2(CAPACITY + 1);

  // Count as it will be once every queued command has been carried out.
  logic [CW-1:0] count;
  logic [CW-1:0] count_next;

  assign busy = q_full;
  assign push = start && !q_full;

  always_comb begin
    cmd.value    = value;
    cmd.position = position;
    cmd.op       = olir_pkg::OP_NONE;
    cmd.status   = olir_pkg::ST_DONE;
    count_next   = count;
    case (req_type)
      olir_pkg::REQ_PUSH_FRONT, olir_pkg::REQ_PUSH_BACK: begin
        if (32'(count) >= CAPACITY) begin
          cmd.status = olir_pkg::ST_FULL;
        end else begin
          cmd.op     = (req_type == olir_pkg::REQ_PUSH_FRONT) ?
                       olir_pkg::OP_PUSH_FRONT : olir_pkg::OP_PUSH_BACK;
          count_next = count + CW'(1);
        end
      end
      olir_pkg::REQ_REMOVE: begin
        if (32'(position) >= 32'(count)) begin
          cmd.status = olir_pkg::ST_RANGE;
        end else begin
          cmd.op     = olir_pkg::OP_REMOVE;
          count_next = count - CW'(1);
        end
      end
      default: begin
        cmd.op = olir_pkg::OP_NONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (push) begin
      count <= count_next;
    end
  end

endmodule

`default_nettype wire

### design/olir_queue.sv
// Short command queue between the front end and the back end.
`default_nettype none

module olir_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire olir_pkg::cmd_t push_cmd,
  input  wire logic           pop,
  output olir_pkg::cmd_t      pop_cmd,
  output logic                full,
  output logic                empty
);

  localparam int DEPTH = olir_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int OW    = $clog2(DEPTH + 1);

  olir_pkg::cmd_t slots [DEPTH];
  logic [PW-1:0]  wr_ptr;
  logic [PW-1:0]  rd_ptr;
  logic [OW-1:0]  fill;

  assign full    = (32'(fill) == DEPTH);
  assign empty   = (fill == '0);
  assign pop_cmd = slots[rd_ptr];

  // DEPTH is a power of two, so the pointers wrap on their own.
  always_ff @(posedge clk) begin
    if (push && !full) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (push && !full) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (pop && !empty) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      case ({push && !full, pop && !empty})
        2'b10:   fill <= fill + OW'(1);
        2'b01:   fill <= fill - OW'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

`default_nettype wire

### design/olir_back.sv
// Back end: carries out queued commands on the circular store and reads the list out.
`default_nettype none

module olir_back #(
  parameter int CAPACITY = olir_pkg::CAPACITY_DEFAULT
) (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              q_empty,
  input  wire olir_pkg::cmd_t                    q_cmd,
  output logic                                   pop,
  output logic                                   result_valid,
  output logic signed [olir_pkg::VALUE_W-1:0]    entry,
  output logic                                   has_entry,
  output logic                                   last,
  output logic [1:0]                             status
);

  localparam int IW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SHIFT,
    S_READ
  } state_t;

  state_t             state;
  olir_pkg::cmd_t     cmd;
  logic [IW-1:0]      head;
  logic [CW-1:0]      count;
  logic [CW-1:0]      rd_pos;
  logic [CW-1:0]      sh_pos;
  logic               sh_pend;
  logic [IW-1:0]      sh_waddr;
  olir_pkg::status_t  status_q;

  logic [IW-1:0]                head_dec;
  logic [CW-1:0]                rd_idx;
  logic [IW-1:0]                rd_addr;
  logic [IW-1:0]                tail_addr;
  logic [IW-1:0]                sh_prev_addr;
  logic                         ram_we;
  logic [IW-1:0]                ram_waddr;
  logic [olir_pkg::VALUE_W-1:0] ram_wdata;
  logic [olir_pkg::VALUE_W-1:0] ram_rdata;
  logic                         read_last;

  // Logical position to store address; head plus index stays below twice the capacity.
  function automatic logic [IW-1:0] phys(input logic [IW-1:0] base, input logic [CW-1:0] idx);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(idx);
    if (32'(sum) >= CAPACITY) begin
      sum = sum - (CW+1)'(CAPACITY);
    end
    return sum[IW-1:0];
  endfunction

  assign head_dec     = (head == '0) ? IW'(CAPACITY - 1) : head - IW'(1);
  assign rd_idx       = (state == S_SHIFT) ? sh_pos : rd_pos;
  assign rd_addr      = phys(head, rd_idx);
  assign tail_addr    = phys(head, count);
  assign sh_prev_addr = phys(head, sh_pos - CW'(1));
  assign read_last    = (count == '0) || ((rd_pos + CW'(1)) == count);
  assign pop          = (state == S_IDLE) && !q_empty;

  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = sh_waddr;
    ram_wdata = ram_rdata;
    if (sh_pend) begin
      ram_we = 1'b1;
    end else if (state == S_EXEC) begin
      ram_wdata = cmd.value;
      case (cmd.op)
        olir_pkg::OP_PUSH_FRONT: begin
          ram_we    = 1'b1;
          ram_waddr = head_dec;
        end
        olir_pkg::OP_PUSH_BACK: begin
          ram_we    = 1'b1;
          ram_waddr = tail_addr;
        end
        default: begin
          ram_we = 1'b0;
        end
      endcase
    end
  end

  olir_ram #(
    .WIDTH (olir_pkg::VALUE_W),
    .DEPTH (CAPACITY)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign entry  = has_entry ? $signed(ram_rdata) : '0;
  assign status = status_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      head         <= '0;
      count        <= '0;
      rd_pos       <= '0;
      sh_pos       <= '0;
      sh_pend      <= 1'b0;
      result_valid <= 1'b0;
      has_entry    <= 1'b0;
      last         <= 1'b0;
      status_q     <= olir_pkg::ST_DONE;
    end else begin
      case (state)
        S_IDLE: begin
          result_valid <= 1'b0;
          sh_pend      <= 1'b0;
          if (!q_empty) begin
            cmd   <= q_cmd;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          result_valid <= 1'b0;
          sh_pend      <= 1'b0;
          rd_pos       <= '0;
          status_q     <= cmd.status;
          state        <= (cmd.op == olir_pkg::OP_REMOVE) ? S_SHIFT : S_READ;
          case (cmd.op)
            olir_pkg::OP_PUSH_FRONT: begin
              head  <= head_dec;
              count <= count + CW'(1);
            end
            olir_pkg::OP_PUSH_BACK: begin
              count <= count + CW'(1);
            end
            olir_pkg::OP_REMOVE: begin
              sh_pos <= CW'(cmd.position) + CW'(1);
            end
            default: begin
              count <= count;
            end
          endcase
        end
        S_SHIFT: begin
          result_valid <= 1'b0;
          // Each entry behind the removed one is read here and written one place down from the registered read data.
          if (sh_pos < count) begin
            sh_pend  <= 1'b1;
            sh_waddr <= sh_prev_addr;
            sh_pos   <= sh_pos + CW'(1);
          end else begin
            sh_pend <= 1'b0;
            count   <= count - CW'(1);
            state   <= S_READ;
          end
        end
        S_READ: begin
          sh_pend      <= 1'b0;
          result_valid <= 1'b1;
          has_entry    <= (count != '0);
          last         <= read_last;
          rd_pos       <= rd_pos + CW'(1);
          if (read_last) begin
            state <= S_IDLE;
          end
        end
        default: begin
          result_valid <= 1'b0;
          sh_pend      <= 1'b0;
          state        <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### design/ordered_list_insert_remove_unit.sv
// Top level of the ordered list insert/remove unit: front end, command queue and back end.
//
//   Channel  | Handshake                  | Beat contents
//   ---------+----------------------------+------------------------------------------
//   request  | start, busy (in when !busy)| req_type, value, position
//   result   | result_valid, one cycle    | entry, has_entry, last, status
//
// A request holds the back end while it is taken off the queue, while it is carried out
// and while the store is read once per entry of the list after it (once for an empty
// list). A removal also passes through a shift state that moves each entry behind the
// removed one down one place. Each result beat is registered behind its read, so the
// last beat overlaps the next request's start. The store has a single read port.
// Reset clears the count, head and queue; store contents need no clearing.
// busy rises while the two-entry command queue is full. Results cannot be stalled.
`default_nettype none

module ordered_list_insert_remove_unit #(
  parameter int CAPACITY = olir_pkg::CAPACITY_DEFAULT
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire logic [olir_pkg::REQ_W-1:0]          req_type,
  input  wire logic signed [olir_pkg::VALUE_W-1:0] value,
  input  wire logic [olir_pkg::POS_W-1:0]          position,
  output logic                                     result_valid,
  output logic signed [olir_pkg::VALUE_W-1:0]      entry,
  output logic                                     has_entry,
  output logic                                     last,
  output logic [1:0]                               status
);

  logic           push;
  logic           pop;
  logic           q_full;
  logic           q_empty;
  olir_pkg::cmd_t push_cmd;
  olir_pkg::cmd_t pop_cmd;

  olir_front #(
    .CAPACITY (CAPACITY)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start),
    .q_full   (q_full),
    .req_type (req_type),
    .value    (value),
    .position (position),
    .busy     (busy),
    .push     (push),
    .cmd      (push_cmd)
  );

  olir_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .full     (q_full),
    .empty    (q_empty)
  );

  olir_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .q_empty      (q_empty),
    .q_cmd        (pop_cmd),
    .pop          (pop),
    .result_valid (result_valid),
    .entry        (entry),
    .has_entry    (has_entry),
    .last         (last),
    .status       (status)
  );

endmodule

`default_nettype wire
